/* hw/rtl/mnat_pkg.sv */
// Shared types and constants for the mesh normalize / affine transform unit.
// No dependencies; compiled first.
package mnat_pkg;

    // Axis bookkeeping
    localparam int NUM_AXES = 3;
    localparam int AX_W     = 2;

    // Rotation register layout: three signed 16-bit entries per row
    localparam int ROT_ENTRY_W = 16;
    localparam int ROT_ROW_W   = NUM_AXES * ROT_ENTRY_W;

    // Identity matrix at reset (Q2.14 one on the diagonal)
    localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_EN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z   = 3'd6;

    // Item codes
    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_EMIT    = 1'b1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXT,
        ST_CTR,
        ST_NORM,
        ST_DIV,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Control into the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic first;
    } t_mac_ctl;

endpackage

/* hw/rtl/mnat_if.sv */
// Valid/ready channel interfaces: vertex input, result output, config write.
// Depends on mnat_pkg.
interface mnat_in_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic                action;
    logic                first_vertex;
    logic signed [W-1:0] in_x;
    logic signed [W-1:0] in_y;
    logic signed [W-1:0] in_z;

    modport source (output valid, action, first_vertex, in_x, in_y, in_z, input ready);
    modport sink   (input valid, action, first_vertex, in_x, in_y, in_z, output ready);
endinterface

interface mnat_out_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] out_x;
    logic signed [W-1:0] out_y;
    logic signed [W-1:0] out_z;
    logic                degenerate_box;
    logic                saturated;

    modport source (output valid, out_x, out_y, out_z, degenerate_box, saturated,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, degenerate_box, saturated,
                    output ready);
endinterface

interface mnat_cfg_if #(parameter int DW = 48) ();
    logic                             valid;
    logic                             ready;
    logic [mnat_pkg::CFG_IDX_W-1:0]   index;
    logic [DW-1:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/mnat_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing beyond the clock and reset.
module mnat_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_q;

    logic [DW:0]   w_rem_sh;
    logic          w_ge;
    logic [DW:0]   w_diff;

    // trial subtract of the shifted remainder
    assign w_rem_sh = {r_rem, r_q[NW-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_den});
    assign w_diff   = w_rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: numerator shifts out the top, quotient bits shift in the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_q   <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_rem_sh[DW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* hw/rtl/mnat_mac.sv */
// Shared multiply-accumulate unit for the rotation: registered product,
// then accumulate. The first term of a row also adds the rounding constant.
// Depends on mnat_pkg.
module mnat_mac #(
    parameter int CW = 32,
    parameter int RF = 14
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  mnat_pkg::t_mac_ctl                        i_ctl,
    input  logic signed [mnat_pkg::ROT_ENTRY_W-1:0]   i_coef,
    input  logic signed [CW-1:0]                      i_data,
    output logic signed [CW+mnat_pkg::ROT_ENTRY_W+1:0] o_acc
);
    import mnat_pkg::*;

    localparam int PW = CW + ROT_ENTRY_W;
    localparam int AW = PW + 2;
    localparam logic signed [AW-1:0] RND = AW'(1) <<< (RF - 1);

    logic                 r_prod_valid;
    logic                 r_prod_first;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_prod_first <= 1'b0;
        end else begin
            r_prod_valid <= i_ctl.valid;
            r_prod_first <= i_ctl.first;
        end
    end

    // multiply, then accumulate the registered product in the cycle after
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= PW'(i_coef) * PW'(i_data);
        end
        if (r_prod_valid) begin
            if (r_prod_first) begin
                r_acc <= AW'(r_prod) + RND;
            end else begin
                r_acc <= r_acc + AW'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

/* hw/rtl/mesh_normalize_affine_transform_unit.sv */
// Mesh normalize and affine transform unit: bounding box, centering, rotation.
// An emit item with centering on finds the largest extent, centers each axis and divides it
// by that extent in the bit-serial divider, one bit per cycle; a zero extent skips the divide.
// With centering off it goes straight to rotation. A measure item folds into the box at its transfer.
// Throughput: one item at a time; the input is not ready while an emit runs.
// Reset (synchronous, active low): box zero, identity rotation, no translation.
module mesh_normalize_affine_transform_unit #(
    parameter int COORD_WIDTH     = 32,
    parameter int COORD_FRAC_BITS = 16,
    parameter int ROT_FRAC_BITS   = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mnat_in_if.sink     i_in,
    mnat_out_if.source  o_out,
    mnat_cfg_if.sink    i_cfg
);
    import mnat_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int NW  = W + COORD_FRAC_BITS + 1;  // divider numerator
    localparam int QW  = NW + 1;                   // signed quotient
    localparam int AW  = W + ROT_ENTRY_W + 2;      // accumulator
    localparam int SW  = AW + 1;                   // rounded sum plus translation

    // configuration
    logic                 r_center_en;
    logic [ROT_ROW_W-1:0] r_rot   [NUM_AXES];
    logic signed [W-1:0]  r_trans [NUM_AXES];

    // box state
    logic signed [W-1:0]  r_box_min [NUM_AXES];
    logic signed [W-1:0]  r_box_max [NUM_AXES];

    // item work registers
    t_state               r_state, n_state;
    logic [AX_W-1:0]      r_ax;
    logic [AX_W-1:0]      r_row;
    logic [AX_W-1:0]      r_col;
    logic signed [W-1:0]  r_v   [NUM_AXES];
    logic signed [W-1:0]  r_n   [NUM_AXES];
    logic signed [W-1:0]  r_res [NUM_AXES];
    logic [W-1:0]         r_ext;
    logic signed [W:0]    r_d;
    logic                 r_neg;
    logic                 r_degen;
    logic                 r_sat;

    // output register
    logic                 r_out_valid;
    logic signed [W-1:0]  r_out [NUM_AXES];
    logic                 r_out_degen;
    logic                 r_out_sat;

    // control
    logic                 w_accept;
    logic                 w_div_start;
    t_mac_ctl             w_mac_ctl;
    logic                 w_out_load;
    logic                 w_ax_last;
    logic                 w_col_last;
    logic                 w_row_last;

    // datapath nets
    logic signed [W:0]    w_ext_e;
    logic signed [W+1:0]  w_ctr_sum;
    logic signed [W+1:0]  w_ctr_d;
    logic signed [W:0]    w_d_abs;
    logic [NW-1:0]        w_num;
    logic                 w_div_done;
    logic [NW-1:0]        w_quo;
    logic signed [QW-1:0] w_quo_s;
    logic                 w_quo_fit;
    logic                 w_d_fit;
    logic signed [W-1:0]  w_quo_sat;
    logic signed [W-1:0]  w_d_sat;
    logic signed [ROT_ENTRY_W-1:0] w_coef;
    logic signed [AW-1:0] w_acc;
    logic signed [SW-1:0] w_sum;
    logic                 w_sum_fit;
    logic signed [W-1:0]  w_sum_sat;
    logic signed [W-1:0]  w_in_v [NUM_AXES];

    assign w_in_v[0] = i_in.in_x;
    assign w_in_v[1] = i_in.in_y;
    assign w_in_v[2] = i_in.in_z;

    assign w_ax_last  = (r_ax  == AX_W'(NUM_AXES - 1));
    assign w_col_last = (r_col == AX_W'(NUM_AXES - 1));
    assign w_row_last = (r_row == AX_W'(NUM_AXES - 1));

    // extent of the current axis, center offset of the current axis
    assign w_ext_e   = {r_box_max[r_ax][W-1], r_box_max[r_ax]}
                     - {r_box_min[r_ax][W-1], r_box_min[r_ax]};
    assign w_ctr_sum = {{2{r_box_max[r_ax][W-1]}}, r_box_max[r_ax]}
                     + {{2{r_box_min[r_ax][W-1]}}, r_box_min[r_ax]};
    assign w_ctr_d   = {{2{r_v[r_ax][W-1]}}, r_v[r_ax]} - (w_ctr_sum >>> 1);

    // divider operands: |d| scaled by 2^(frac+1) over the extent
    assign w_d_abs = r_d[W] ? -r_d : r_d;
    assign w_num   = {w_d_abs[W-1:0], {(COORD_FRAC_BITS + 1){1'b0}}};

    mnat_div #(
        .NW (NW),
        .DW (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_ext),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // signed quotient, truncated toward zero, then saturated
    assign w_quo_s   = r_neg ? -{1'b0, w_quo} : {1'b0, w_quo};
    assign w_quo_fit = (w_quo_s[QW-1:W-1] == '0) || (w_quo_s[QW-1:W-1] == '1);
    assign w_quo_sat = w_quo_fit ? w_quo_s[W-1:0]
                     : (w_quo_s[QW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // zero extent: centered value only, saturated
    assign w_d_fit = (r_d[W:W-1] == 2'b00) || (r_d[W:W-1] == 2'b11);
    assign w_d_sat = w_d_fit ? r_d[W-1:0]
                   : (r_d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // rotation through the shared multiplier
    assign w_coef = r_rot[r_row][ROT_ENTRY_W * r_col +: ROT_ENTRY_W];

    mnat_mac #(
        .CW (W),
        .RF (ROT_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_coef  (w_coef),
        .i_data  (r_n[r_col]),
        .o_acc   (w_acc)
    );

    // floor shift of the rounded sum, add translation, saturate
    assign w_sum     = SW'(w_acc >>> ROT_FRAC_BITS) + SW'(r_trans[r_row]);
    assign w_sum_fit = (w_sum[SW-1:W-1] == '0) || (w_sum[SW-1:W-1] == '1);
    assign w_sum_sat = w_sum_fit ? w_sum[W-1:0]
                     : (w_sum[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.action == ACT_EMIT) begin
                    n_state = r_center_en ? ST_EXT : ST_MAC;
                end
            end
            ST_EXT:   n_state = w_ax_last ? ST_CTR : ST_EXT;
            ST_CTR:   n_state = ST_NORM;
            ST_NORM: begin
                if (r_degen) begin
                    n_state = w_ax_last ? ST_MAC : ST_CTR;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = w_ax_last ? ST_MAC : ST_CTR;
                end
            end
            ST_MAC:   n_state = w_col_last ? ST_DRAIN : ST_MAC;
            ST_DRAIN: n_state = ST_ROUND;
            ST_ROUND: n_state = w_row_last ? ST_OUT : ST_MAC;
            ST_OUT:   n_state = (!r_out_valid || o_out.ready) ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        w_accept        = 1'b0;
        w_div_start     = 1'b0;
        w_mac_ctl.valid = 1'b0;
        w_mac_ctl.first = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:  w_accept    = i_in.valid;
            ST_NORM:  w_div_start = !r_degen;
            ST_MAC: begin
                w_mac_ctl.valid = 1'b1;
                w_mac_ctl.first = (r_col == '0);
            end
            ST_OUT:   w_out_load  = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // state, configuration and box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_center_en <= 1'b0;
            r_rot[0]    <= ROT_ROW0_RST;
            r_rot[1]    <= ROT_ROW1_RST;
            r_rot[2]    <= ROT_ROW2_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_trans[i]   <= '0;
                r_box_min[i] <= '0;
                r_box_max[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration write transfer
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_CENTER_EN: r_center_en <= i_cfg.data[0];
                    REG_ROT_ROW0:  r_rot[0]    <= i_cfg.data[ROT_ROW_W-1:0];
                    REG_ROT_ROW1:  r_rot[1]    <= i_cfg.data[ROT_ROW_W-1:0];
                    REG_ROT_ROW2:  r_rot[2]    <= i_cfg.data[ROT_ROW_W-1:0];
                    REG_TRANS_X:   r_trans[0]  <= i_cfg.data[W-1:0];
                    REG_TRANS_Y:   r_trans[1]  <= i_cfg.data[W-1:0];
                    REG_TRANS_Z:   r_trans[2]  <= i_cfg.data[W-1:0];
                    default: ;
                endcase
            end

            // measure item folds into the box at its transfer
            if (w_accept && i_in.action == ACT_MEASURE) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    if (i_in.first_vertex) begin
                        r_box_min[i] <= w_in_v[i];
                        r_box_max[i] <= w_in_v[i];
                    end else begin
                        if (w_in_v[i] < r_box_min[i]) r_box_min[i] <= w_in_v[i];
                        if (w_in_v[i] > r_box_max[i]) r_box_max[i] <= w_in_v[i];
                    end
                end
            end
        end
    end

    // emit datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    r_v[i] <= w_in_v[i];
                    r_n[i] <= w_in_v[i];
                end
                r_ax    <= '0;
                r_row   <= '0;
                r_col   <= '0;
                r_ext   <= '0;
                r_degen <= 1'b0;
                r_sat   <= 1'b0;
            end
            ST_EXT: begin
                if (!w_ext_e[W] && (w_ext_e[W-1:0] > r_ext)) begin
                    r_ext <= w_ext_e[W-1:0];
                end
                r_ax <= w_ax_last ? '0 : r_ax + 1'b1;
            end
            ST_CTR: begin
                r_d     <= w_ctr_d[W:0];
                r_degen <= (r_ext == '0);
            end
            ST_NORM: begin
                r_neg <= r_d[W];
                if (r_degen) begin
                    r_n[r_ax] <= w_d_sat;
                    if (!w_d_fit) r_sat <= 1'b1;
                    r_ax <= r_ax + 1'b1;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    r_n[r_ax] <= w_quo_sat;
                    if (!w_quo_fit) r_sat <= 1'b1;
                    r_ax <= r_ax + 1'b1;
                end
            end
            ST_MAC: begin
                r_col <= w_col_last ? '0 : r_col + 1'b1;
            end
            ST_ROUND: begin
                r_res[r_row] <= w_sum_sat;
                if (!w_sum_fit) r_sat <= 1'b1;
                r_row <= r_row + 1'b1;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_out[i] <= r_res[i];
            end
            r_out_degen <= r_degen;
            r_out_sat   <= r_sat;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_x          = r_out[0];
    assign o_out.out_y          = r_out[1];
    assign o_out.out_z          = r_out[2];
    assign o_out.degenerate_box = r_out_degen;
    assign o_out.saturated      = r_out_sat;

endmodule
